FILE: rtl/los3d_pkg.sv
// ----------------------------------------------------------------------------
// los3d_pkg: shared types and constants of the line-of-sight walker
// Widths, command codes, controller states and the control and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package los3d_pkg;

    // Map geometry. The map is square with a power-of-two side.
    localparam int COORD_W   = 6;
    localparam int MAP_DIM   = 2 ** COORD_W;
    localparam int CELLS     = MAP_DIM * MAP_DIM;
    localparam int CELL_W    = 2 * COORD_W;

    // Tile contents and height scaling.
    localparam int ELEV_BITS    = 8;
    localparam int TILE_W       = ELEV_BITS + 1;
    localparam int HEIGHT_SCALE = 1024;
    localparam int EYE_RAISE    = 2;

    // Scaled heights and the Bresenham error terms.
    localparam int Z_W = 19;
    localparam int E_W = Z_W + 3;

    localparam int AXES = 3;

    typedef logic [COORD_W-1:0]     t_coord;
    typedef logic [Z_W-1:0]         t_z;
    typedef logic signed [E_W-1:0]  t_err;
    typedef logic [CELL_W-1:0]      t_cell;
    typedef logic [ELEV_BITS-1:0]   t_elev;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_SRC,
        S_RD_DST,
        S_SETUP,
        S_AXIS,
        S_WALK
    } t_state;

    // Selects which tile the map read port fetches.
    typedef enum logic [1:0] {
        RS_SRC,
        RS_DST,
        RS_CUR,
        RS_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic    wr_en;
        logic    load_item;
        logic    lat_z1;
        logic    setup;
        logic    init_walk;
        logic    step;
        logic    load_out;
        t_rd_sel rd_sel;
    } t_ctl_cmd;

    typedef struct packed {
        logic finish;
    } t_dp_status;

    // Scaled height of an elevation.
    function automatic t_z f_scale(input t_elev e);
        return Z_W'(e) * Z_W'(HEIGHT_SCALE);
    endfunction

endpackage

FILE: rtl/los3d_ctrl.sv
// ----------------------------------------------------------------------------
// los3d_ctrl: sequencer of the line-of-sight walker
// Handles both handshakes, steps a query through its map reads, setup and
// walk, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module los3d_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  los3d_pkg::t_dp_status  i_status,
    output los3d_pkg::t_ctl_cmd    o_ctl
);
    import los3d_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_cmd == CMD_QUERY) begin
                    n_state = S_RD_SRC;
                end
            end
            S_RD_SRC: n_state = S_RD_DST;
            S_RD_DST: n_state = S_SETUP;
            S_SETUP:  n_state = S_AXIS;
            S_AXIS:   n_state = S_WALK;
            S_WALK: begin
                if (i_status.finish && w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.rd_sel = RS_SRC;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.wr_en     = (i_cmd == CMD_WRITE);
                    o_ctl.load_item = (i_cmd == CMD_QUERY);
                end
            end
            S_RD_SRC: o_ctl.rd_sel = RS_SRC;
            S_RD_DST: begin
                o_ctl.rd_sel = RS_DST;
                o_ctl.lat_z1 = 1'b1;
            end
            S_SETUP:  o_ctl.setup = 1'b1;
            S_AXIS: begin
                o_ctl.init_walk = 1'b1;
                o_ctl.rd_sel    = RS_SRC;
            end
            S_WALK: begin
                if (i_status.finish) begin
                    // Keep the current tile in the read register while we wait.
                    o_ctl.rd_sel   = RS_CUR;
                    o_ctl.load_out = w_slot_free;
                end else begin
                    o_ctl.rd_sel = RS_NEXT;
                    o_ctl.step   = 1'b1;
                end
            end
            default: o_ctl = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken word");

    a_step_or_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.step && o_ctl.load_out))
        else $error("walk stepped and finished in the same cycle");

    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WALK))
        else $error("result appeared outside of a walk");

endmodule

FILE: rtl/los3d_dp.sv
// ----------------------------------------------------------------------------
// los3d_dp: datapath of the line-of-sight walker
// Holds the tile map memory, the query endpoints, the Bresenham stepper
// and the result register.
// ----------------------------------------------------------------------------
module los3d_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  los3d_pkg::t_ctl_cmd    i_ctl,
    output los3d_pkg::t_dp_status  o_status,
    input  los3d_pkg::t_coord      i_src_x,
    input  los3d_pkg::t_coord      i_src_y,
    input  logic [7:0]             i_tile_elevation,
    input  logic                   i_tile_blocks,
    input  los3d_pkg::t_coord      i_dst_x,
    input  los3d_pkg::t_coord      i_dst_y,
    output logic                   o_visible,
    output los3d_pkg::t_coord      o_block_x,
    output los3d_pkg::t_coord      o_block_y,
    output los3d_pkg::t_z          o_block_z
);
    import los3d_pkg::*;

    // Tile map: {blocks flag, elevation}.
    logic [TILE_W-1:0] r_tile_mem [CELLS];
    logic [TILE_W-1:0] r_rd_data;
    t_cell             w_rd_addr;
    t_cell             w_wr_addr;

    t_coord r_sx, r_sy, r_tx, r_ty;
    t_z     r_z1;
    t_z     r_len  [AXES];
    logic   r_neg  [AXES];
    logic   r_major[AXES];
    t_z     r_la;
    t_z     r_cnt;
    t_z     r_p    [AXES];
    t_err   r_e    [AXES];

    t_z     n_p    [AXES];
    t_err   n_e    [AXES];
    logic   w_move [AXES];
    t_err   w_len2 [AXES];
    t_err   w_la2;

    t_elev  w_elev;
    logic   w_flag;
    t_z     w_z2;
    logic signed [COORD_W:0] w_dx, w_dy;
    logic signed [Z_W:0]     w_dz, w_adz;
    logic signed [COORD_W:0] w_adx, w_ady;
    logic   w_done, w_blocked;

    logic   r_visible;
    t_coord r_bx, r_by;
    t_z     r_bz;

    assign w_elev = r_rd_data[ELEV_BITS-1:0];
    assign w_flag = r_rd_data[ELEV_BITS];

    // ---------------------------------------------------------------- memory
    assign w_wr_addr = {i_src_y, i_src_x};

    always_comb begin
        case (i_ctl.rd_sel)
            RS_SRC:  w_rd_addr = {r_sy, r_sx};
            RS_DST:  w_rd_addr = {r_ty, r_tx};
            RS_CUR:  w_rd_addr = {r_p[1][COORD_W-1:0], r_p[0][COORD_W-1:0]};
            RS_NEXT: w_rd_addr = {n_p[1][COORD_W-1:0], n_p[0][COORD_W-1:0]};
            default: w_rd_addr = {r_sy, r_sx};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_tile_mem[w_wr_addr] <= {i_tile_blocks, i_tile_elevation[ELEV_BITS-1:0]};
        end
        r_rd_data <= r_tile_mem[w_rd_addr];
    end

    // ----------------------------------------------------------------- setup
    always_comb begin
        w_z2  = f_scale(w_elev);
        w_dx  = signed'({1'b0, r_tx}) - signed'({1'b0, r_sx});
        w_dy  = signed'({1'b0, r_ty}) - signed'({1'b0, r_sy});
        w_dz  = signed'({1'b0, w_z2}) - signed'({1'b0, r_z1});
        w_adx = w_dx[COORD_W] ? -w_dx : w_dx;
        w_ady = w_dy[COORD_W] ? -w_dy : w_dy;
        w_adz = w_dz[Z_W] ? -w_dz : w_dz;
    end

    // ------------------------------------------------------------- stepper
    assign w_la2 = signed'({{(E_W-Z_W-1){1'b0}}, r_la, 1'b0});

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_len2[k] = signed'({{(E_W-Z_W-1){1'b0}}, r_len[k], 1'b0});
            n_e[k]    = r_e[k];
            if (r_major[k]) begin
                w_move[k] = 1'b1;
            end else begin
                w_move[k] = (r_e[k] > 0);
                n_e[k]    = r_e[k] - (w_move[k] ? w_la2 : t_err'(0)) + w_len2[k];
            end
            if (!w_move[k]) begin
                n_p[k] = r_p[k];
            end else if (r_neg[k]) begin
                n_p[k] = r_p[k] - Z_W'(1);
            end else begin
                n_p[k] = r_p[k] + Z_W'(1);
            end
        end
    end

    assign w_done    = (r_cnt == r_la);
    assign w_blocked = w_flag && (f_scale(w_elev) > r_p[2]);
    assign o_status.finish = w_done || w_blocked;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_sx <= i_src_x;
            r_sy <= i_src_y;
            r_tx <= i_dst_x;
            r_ty <= i_dst_y;
        end
        if (i_ctl.lat_z1) begin
            // The eye sits two meters above the source tile.
            r_z1 <= f_scale(w_elev) + t_z'(EYE_RAISE * HEIGHT_SCALE);
        end
        if (i_ctl.setup) begin
            r_len[0] <= Z_W'(unsigned'(w_adx));
            r_len[1] <= Z_W'(unsigned'(w_ady));
            r_len[2] <= w_adz[Z_W-1:0];
            r_neg[0] <= w_dx[COORD_W];
            r_neg[1] <= w_dy[COORD_W];
            r_neg[2] <= w_dz[Z_W];
        end
        if (i_ctl.init_walk) begin
            // Ties go to x, then to y.
            if (r_len[0] >= r_len[1] && r_len[0] >= r_len[2]) begin
                r_major[0] <= 1'b1;
                r_major[1] <= 1'b0;
                r_major[2] <= 1'b0;
                r_la       <= r_len[0];
                for (int k = 0; k < AXES; k++) begin
                    r_e[k] <= w_len2[k] - t_err'(r_len[0]);
                end
            end else if (r_len[1] >= r_len[2]) begin
                r_major[0] <= 1'b0;
                r_major[1] <= 1'b1;
                r_major[2] <= 1'b0;
                r_la       <= r_len[1];
                for (int k = 0; k < AXES; k++) begin
                    r_e[k] <= w_len2[k] - t_err'(r_len[1]);
                end
            end else begin
                r_major[0] <= 1'b0;
                r_major[1] <= 1'b0;
                r_major[2] <= 1'b1;
                r_la       <= r_len[2];
                for (int k = 0; k < AXES; k++) begin
                    r_e[k] <= w_len2[k] - t_err'(r_len[2]);
                end
            end
            r_p[0] <= Z_W'(r_sx);
            r_p[1] <= Z_W'(r_sy);
            r_p[2] <= r_z1;
            r_cnt  <= '0;
        end
        if (i_ctl.step) begin
            for (int k = 0; k < AXES; k++) begin
                r_p[k] <= n_p[k];
                r_e[k] <= n_e[k];
            end
            r_cnt <= r_cnt + Z_W'(1);
        end
        if (i_ctl.load_out) begin
            r_visible <= w_done;
            r_bx      <= w_done ? '0 : r_p[0][COORD_W-1:0];
            r_by      <= w_done ? '0 : r_p[1][COORD_W-1:0];
            r_bz      <= w_done ? '0 : r_p[2];
        end
    end

    assign o_visible = r_visible;
    assign o_block_x = r_bx;
    assign o_block_y = r_by;
    assign o_block_z = r_bz;

    a_walk_within_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step |-> (r_cnt < r_la))
        else $error("walk stepped past the major axis length");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step |=> (r_cnt == $past(r_cnt) + Z_W'(1)))
        else $error("point counter did not advance on a step");

    a_one_major_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.init_walk |=> $onehot({r_major[2], r_major[1], r_major[0]}))
        else $error("walk did not pick exactly one major axis");

endmodule

FILE: rtl/line_of_sight_3d_walk.sv
// ----------------------------------------------------------------------------
// line_of_sight_3d_walk: tile map with a 3D Bresenham line-of-sight query
// Stores elevation and blocking flag per tile and answers visibility queries
// between two tiles, reporting the first blocking point of the walk.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Words
//  --------  ---------  -------------------------  --------------------------
//  in        to block   i_in_valid / o_in_ready    tile write or query
//  out       from block o_out_valid / i_out_ready  one per query, none per write
//
// A tile write leaves the controller idle, so the next word can follow it. A query
// runs from its acceptance through the two map reads, setup and the walk, which
// visits points until the target is reached or a blocking tile is found; the
// single read port of the tile map fetches one point per cycle during the walk.
// Reset (i_rst_n low at a clock edge) returns the controller to idle and
// empties the result register; the tile map keeps no reset value.
// A result that is not taken stalls only the end of the next query; new
// words are accepted as soon as the controller is idle.
//
module line_of_sight_3d_walk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [5:0]           i_src_x,
    input  logic [5:0]           i_src_y,
    input  logic [7:0]           i_tile_elevation,
    input  logic                 i_tile_blocks,
    input  logic [5:0]           i_dst_x,
    input  logic [5:0]           i_dst_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_visible,
    output logic [5:0]           o_block_x,
    output logic [5:0]           o_block_y,
    output logic [18:0]          o_block_z
);
    import los3d_pkg::*;

    // Commands from the controller and the walk status back to it.
    t_ctl_cmd   w_ctl;
    t_dp_status w_status;

    // The controller sequences each query: two map reads for the end heights,
    // a setup step for the deltas, one to pick the major axis, then the walk.
    los3d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_ctl       (w_ctl)
    );

    // The datapath holds the tile map, the stepper and the result word.
    los3d_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_status         (w_status),
        .i_src_x          (i_src_x),
        .i_src_y          (i_src_y),
        .i_tile_elevation (i_tile_elevation),
        .i_tile_blocks    (i_tile_blocks),
        .i_dst_x          (i_dst_x),
        .i_dst_y          (i_dst_y),
        .o_visible        (o_visible),
        .o_block_x        (o_block_x),
        .o_block_y        (o_block_y),
        .o_block_z        (o_block_z)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the line-of-sight walker
// Drives tile writes and sight queries through the valid/ready input channel,
// predicts untyped query answers with an independent 3D Bresenham walk over a
// private copy of the tile map, and checks each returned word field by field.
// ----------------------------------------------------------------------------
module testbench;

    import los3d_pkg::*;

    // One query answer as it leaves the block.
    typedef struct packed {
        logic   visible;
        t_coord x;
        t_coord y;
        t_z     z;
    } sight_t;

    // One row of the directed part.
    typedef struct {
        logic   cmd;
        t_coord sx;
        t_coord sy;
        t_elev  elev;
        logic   blk;
        t_coord dx;
        t_coord dy;
        bit     typed;
        sight_t want;
    } drill_row_t;

    localparam sight_t SEEN  = '{visible: 1'b1, x: '0, y: '0, z: '0};
    localparam int ITEMS        = 450;
    localparam int TAIL_START   = 400;
    localparam int LONG_STALL   = 12000;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int REUSE_SPAN   = 4096;
    localparam int DRILL_ROWS   = 18;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [5:0]  i_src_x;
    logic [5:0]  i_src_y;
    logic [7:0]  i_tile_elevation;
    logic        i_tile_blocks;
    logic [5:0]  i_dst_x;
    logic [5:0]  i_dst_y;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_visible;
    logic [5:0]  o_block_x;
    logic [5:0]  o_block_y;
    logic [18:0] o_block_z;

    line_of_sight_3d_walk u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_src_x          (i_src_x),
        .i_src_y          (i_src_y),
        .i_tile_elevation (i_tile_elevation),
        .i_tile_blocks    (i_tile_blocks),
        .i_dst_x          (i_dst_x),
        .i_dst_y          (i_dst_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_visible        (o_visible),
        .o_block_x        (o_block_x),
        .o_block_y        (o_block_y),
        .o_block_z        (o_block_z)
    );

    // Private copy of the tile map. tile_known marks tiles that have been
    // written, so that no query ever walks over a tile with no defined value.
    t_elev  elev_map   [CELLS];
    bit     blocks_map [CELLS];
    bit     tile_known [CELLS];

    sight_t sight_q [$];     // answers still owed by the block, oldest first
    t_cell  walk_cells [$];  // tiles crossed by the last surveyed walk

    int  fail_count     = 0;
    int  item_count     = 0;
    int  cycle_count    = 0;
    int  idle_odds      = 0;  // 0: no idling, else one burst in idle_odds
    int  stall_left     = 0;
    bit  long_stall_req = 1'b0;

    // Directed part. The answers typed in here follow directly from the tiles
    // written just before: a walk that never leaves one tile is always seen,
    // and a flat walk over a tall flagged tile stops there at the eye height.
    drill_row_t drill [DRILL_ROWS] = '{
        '{CMD_WRITE, 6'd0,  6'd0,  8'd0,   1'b0, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_WRITE, 6'd63, 6'd63, 8'd255, 1'b1, 6'd63, 6'd63, 1'b0, SEEN},
        '{CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b0, 6'd0,  6'd0,  1'b1, SEEN},
        '{CMD_QUERY, 6'd63, 6'd63, 8'd255, 1'b1, 6'd63, 6'd63, 1'b1, SEEN},
        '{CMD_WRITE, 6'd1,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_WRITE, 6'd2,  6'd0,  8'd255, 1'b1, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_WRITE, 6'd3,  6'd0,  8'd2,   1'b0, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b0, 6'd3,  6'd0,  1'b1,
          '{visible: 1'b0, x: 6'd2, y: 6'd0, z: 19'd2048}},
        '{CMD_WRITE, 6'd0,  6'd1,  8'd0,   1'b0, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_WRITE, 6'd0,  6'd2,  8'd2,   1'b1, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b0, 6'd0,  6'd2,  1'b1, SEEN},
        '{CMD_QUERY, 6'd3,  6'd0,  8'd0,   1'b0, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_WRITE, 6'd63, 6'd62, 8'd253, 1'b1, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_QUERY, 6'd63, 6'd63, 8'd0,   1'b0, 6'd63, 6'd62, 1'b0, SEEN},
        '{CMD_QUERY, 6'd63, 6'd62, 8'd0,   1'b0, 6'd63, 6'd63, 1'b0, SEEN},
        '{CMD_WRITE, 6'd0,  6'd0,  8'd255, 1'b1, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b0, 6'd0,  6'd0,  1'b0, SEEN},
        '{CMD_QUERY, 6'd1,  6'd0,  8'd0,   1'b0, 6'd2,  6'd0,  1'b0, SEEN}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_cell cell_at(input t_coord x, input t_coord y);
        return {y, x};
    endfunction

    function automatic t_elev clamp_elev(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return t_elev'(v);
    endfunction

    // Walks the 3D Bresenham line from the eye above the source tile to the
    // target. The major axis is the longest of x, y and scaled z, with ties
    // going to x and then y. Every point short of the target is tested, so a
    // walk along z over one tile is always seen. In survey mode nothing is
    // tested; the tiles crossed are collected instead, and span returns the
    // number of points the walk visits.
    function automatic void trace_sight(input t_coord sx, input t_coord sy,
                                        input t_coord tx, input t_coord ty,
                                        input bit survey,
                                        output sight_t seen, output longint span);
        longint p [3];
        longint d [3];
        longint step [3];
        longint len [3];
        longint err [3];
        longint ground;
        longint i;
        int     a;
        int     b;
        int     c;
        t_cell  w;
        seen = SEEN;
        p[0] = longint'(sx);
        p[1] = longint'(sy);
        p[2] = (longint'(elev_map[cell_at(sx, sy)]) + EYE_RAISE) * HEIGHT_SCALE;
        d[0] = longint'(tx) - p[0];
        d[1] = longint'(ty) - p[1];
        d[2] = longint'(elev_map[cell_at(tx, ty)]) * HEIGHT_SCALE - p[2];
        for (int k = 0; k < 3; k++) begin
            step[k] = (d[k] < 0) ? -1 : 1;
            len[k]  = (d[k] < 0) ? -d[k] : d[k];
        end
        if (len[0] >= len[1] && len[0] >= len[2]) begin
            a = 0; b = 1; c = 2;
        end else if (len[1] >= len[0] && len[1] >= len[2]) begin
            a = 1; b = 0; c = 2;
        end else begin
            a = 2; b = 1; c = 0;
        end
        span   = len[a];
        err[b] = 2 * len[b] - len[a];
        err[c] = 2 * len[c] - len[a];
        for (i = 0; i < len[a]; i++) begin
            w = cell_at(t_coord'(p[0]), t_coord'(p[1]));
            if (survey) begin
                // The path is monotonic, so repeats are always adjacent.
                if (walk_cells.size() == 0 || walk_cells[$] != w) begin
                    walk_cells.push_back(w);
                end
            end else begin
                ground = longint'(elev_map[w]) * HEIGHT_SCALE;
                if (ground > p[2] && blocks_map[w]) begin
                    seen.visible = 1'b0;
                    seen.x       = t_coord'(p[0]);
                    seen.y       = t_coord'(p[1]);
                    seen.z       = t_z'(p[2]);
                    return;
                end
            end
            if (err[b] > 0) begin
                p[b]   += step[b];
                err[b] -= 2 * len[a];
            end
            if (err[c] > 0) begin
                p[c]   += step[c];
                err[c] -= 2 * len[a];
            end
            err[b] += 2 * len[b];
            err[c] += 2 * len[c];
            p[a]   += step[a];
        end
    endfunction

    // Offers one word on the input channel, after an optional burst of idle
    // cycles, and holds it until accepted. On acceptance the private map is
    // updated for a write, and the answer owed for a query is queued: typed in
    // for directed rows that carry one, otherwise predicted by the walk.
    task automatic send_word(input logic cmd, input t_coord sx, input t_coord sy,
                             input t_elev el, input logic blk,
                             input t_coord dx, input t_coord dy,
                             input bit typed, input sight_t want);
        int     gap;
        sight_t answer;
        longint span;
        gap = 0;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cmd            = cmd;
        i_src_x          = sx;
        i_src_y          = sy;
        i_tile_elevation = el;
        i_tile_blocks    = blk;
        i_dst_x          = dx;
        i_dst_y          = dy;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        item_count++;
        if (cmd == CMD_WRITE) begin
            elev_map[cell_at(sx, sy)]   = el;
            blocks_map[cell_at(sx, sy)] = blk;
            tile_known[cell_at(sx, sy)] = 1'b1;
        end else if (typed) begin
            sight_q.push_back(want);
        end else begin
            trace_sight(sx, sy, dx, dy, 1'b0, answer, span);
            sight_q.push_back(answer);
        end
    endtask

    // Receiver. Ready drops for random bursts while idling is on, and for one
    // long hold on request, so that a finished query finds the result register
    // still full and the input channel backs up behind it.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            i_out_ready    = 1'b0;
            stall_left     = LONG_STALL - 1;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            i_out_ready = 1'b0;
            stall_left  = $urandom_range(1, 19) - 1;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // Answer checker: every word taken is compared with the oldest owed one.
    always @(posedge i_clk) begin : check_answer
        sight_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sight_q.size() == 0) begin
                $display("%0t: answer with none owed: visible %0d at (%0d,%0d) z %0d",
                         $time, o_visible, o_block_x, o_block_y, o_block_z);
                fail_count++;
            end else begin
                want = sight_q.pop_front();
                if (o_visible !== want.visible) begin
                    $display("%0t: visible expected %0d actual %0d",
                             $time, want.visible, o_visible);
                    fail_count++;
                end
                if (o_block_x !== want.x) begin
                    $display("%0t: block_x expected %0d actual %0d",
                             $time, want.x, o_block_x);
                    fail_count++;
                end
                if (o_block_y !== want.y) begin
                    $display("%0t: block_y expected %0d actual %0d",
                             $time, want.y, o_block_y);
                    fail_count++;
                end
                if (o_block_z !== want.z) begin
                    $display("%0t: block_z expected %0d actual %0d",
                             $time, want.z, o_block_z);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_coord sx;
        t_coord sy;
        t_coord tx;
        t_coord ty;
        t_cell  src_cell;
        t_cell  dst_cell;
        t_elev  base;
        t_elev  e_dst;
        t_elev  e_path;
        sight_t scratch;
        longint span;
        bit     reuse;
        bit     stall_done;
        bit     pause_done;
        int     tall_left;
        int     next_odds_at;
        int     n;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_cmd            = CMD_WRITE;
        i_src_x          = '0;
        i_src_y          = '0;
        i_tile_elevation = '0;
        i_tile_blocks    = 1'b0;
        i_dst_x          = '0;
        i_dst_y          = '0;
        stall_done       = 1'b0;
        pause_done       = 1'b0;
        tall_left        = 2;
        next_odds_at     = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (n = 0; n < DRILL_ROWS; n++) begin
            send_word(drill[n].cmd, drill[n].sx, drill[n].sy, drill[n].elev,
                      drill[n].blk, drill[n].dx, drill[n].dy,
                      drill[n].typed, drill[n].want);
        end

        // Random part. Each round is a well-formed query: the source and
        // target tiles are written (or reused when already known and the walk
        // stays short), every unknown tile on the path is filled in, and then
        // the query goes out. Stray writes to random tiles are mixed in.
        while (item_count < ITEMS) begin
            if (item_count >= TAIL_START) begin
                idle_odds = 0;
            end else if (item_count >= next_odds_at) begin
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    default: idle_odds = 8;
                endcase
                next_odds_at = item_count + 40;
            end
            if (!stall_done && item_count >= 150) begin
                long_stall_req = 1'b1;
                stall_done     = 1'b1;
            end
            if (!pause_done && item_count >= 300) begin
                // Hold the sender until every owed answer has come back.
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (sight_q.size() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end

            if ($urandom_range(0, 9) == 0) begin
                send_word(CMD_WRITE, t_coord'($urandom), t_coord'($urandom),
                          t_elev'($urandom), 1'($urandom),
                          t_coord'($urandom), t_coord'($urandom), 1'b0, SEEN);
            end

            sx = t_coord'($urandom);
            sy = t_coord'($urandom);
            if ($urandom_range(0, 4) == 0) begin
                tx = t_coord'($urandom);
                ty = t_coord'($urandom);
            end else begin
                tx = t_coord'(int'(sx) + int'($urandom_range(0, 12)) - 6);
                ty = t_coord'(int'(sy) + int'($urandom_range(0, 12)) - 6);
            end
            src_cell = cell_at(sx, sy);
            dst_cell = cell_at(tx, ty);

            reuse = tile_known[src_cell] && tile_known[dst_cell]
                    && ($urandom_range(0, 3) == 0);
            if (reuse) begin
                walk_cells.delete();
                trace_sight(sx, sy, tx, ty, 1'b1, scratch, span);
                if (span > REUSE_SPAN) begin
                    reuse = 1'b0;
                end
            end
            if (!reuse) begin
                // Keep the target close to the eye height: the walk runs
                // about a thousand points per meter of difference. Only a
                // couple of rounds get a target anywhere in range.
                base = t_elev'($urandom);
                if (tall_left > 0 && $urandom_range(0, 39) == 0) begin
                    e_dst = t_elev'($urandom);
                    tall_left--;
                end else begin
                    e_dst = clamp_elev(int'(base) + 2 + int'($urandom_range(0, 6)) - 3);
                end
                send_word(CMD_WRITE, sx, sy, base, 1'($urandom),
                          t_coord'($urandom), t_coord'($urandom), 1'b0, SEEN);
                if (dst_cell != src_cell) begin
                    send_word(CMD_WRITE, tx, ty, e_dst, 1'($urandom),
                              t_coord'($urandom), t_coord'($urandom), 1'b0, SEEN);
                end
            end

            // The path depends only on the two end tiles, so writes to the
            // tiles between them leave it unchanged.
            walk_cells.delete();
            trace_sight(sx, sy, tx, ty, 1'b1, scratch, span);
            foreach (walk_cells[k]) begin
                if (walk_cells[k] != src_cell && walk_cells[k] != dst_cell
                    && (!tile_known[walk_cells[k]] || $urandom_range(0, 9) == 0)) begin
                    if ($urandom_range(0, 6) == 0) begin
                        e_path = t_elev'($urandom);
                    end else begin
                        e_path = clamp_elev(int'(elev_map[src_cell])
                                            + int'($urandom_range(0, 5)));
                    end
                    send_word(CMD_WRITE, walk_cells[k][COORD_W-1:0],
                              walk_cells[k][CELL_W-1:COORD_W], e_path, 1'($urandom),
                              t_coord'($urandom), t_coord'($urandom), 1'b0, SEEN);
                end
            end

            send_word(CMD_QUERY, sx, sy, t_elev'($urandom), 1'($urandom),
                      tx, ty, 1'b0, SEEN);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sight_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/los3d_pkg.sv
rtl/los3d_ctrl.sv
rtl/los3d_dp.sv
rtl/line_of_sight_3d_walk.sv
dv/testbench.sv
